### rtl/mesh_boundary_edge_counter_defines.svh
`ifndef MESH_BOUNDARY_EDGE_COUNTER_DEFINES_SVH
`define MESH_BOUNDARY_EDGE_COUNTER_DEFINES_SVH

// same-cycle implication
`define MBEC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mbec check failed");

// next-cycle implication
`define MBEC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mbec check failed");

`endif

### rtl/mbec_pkg.sv
`timescale 1ns / 1ps
package mbec_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int VERTEX_BITS = 20;

    localparam logic [31:0] HASH_MUL_LO = 32'd73856093;
    localparam logic [31:0] HASH_MUL_HI = 32'd19349669;

    localparam logic [1:0]  USE_MAX   = 2'd3;
    localparam int          TOTAL_MAX = 8191;
    localparam int          TOTAL_W   = 13;

    localparam logic [15:0] DIVISOR_RESET = 16'd200;
    localparam logic [7:0]  MIN_RESET     = 8'd10;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DIVISOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_UNIQUE    = 2'd1;

    localparam logic MODE_FACE   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HASH   = 6'b000010,
        S_READ   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_REPORT = 6'b010000,
        S_CLEAR  = 6'b100000
    } t_state;
endpackage

### rtl/mesh_boundary_edge_counter.sv
`timescale 1ns / 1ps
// Face: edges a-b, b-c, c-a, each a hash step plus a read and a check/write step per probe;
//   the next face is taken only once the last edge is done and the block is idle.
// Finish: result valid after the S_REPORT state that follows the transfer, then
//   a pass clearing every table slot, during which no item is taken.
// Reset (synchronous, active low): starts the same clearing pass;
//   config port stays open throughout.
module mesh_boundary_edge_counter #(
    parameter int P_TABLE_DEPTH = mbec_pkg::TABLE_DEPTH,
    parameter int P_VERTEX_BITS = mbec_pkg::VERTEX_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [P_VERTEX_BITS-1:0]       i_corner_a,
    input  logic [P_VERTEX_BITS-1:0]       i_corner_b,
    input  logic [P_VERTEX_BITS-1:0]       i_corner_c,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mbec_pkg::TOTAL_W-1:0]   o_boundary_edges,
    output logic [mbec_pkg::TOTAL_W-1:0]   o_unique_edges,
    output logic                           o_watertight,
    output logic                           o_too_few_edges,
    output logic                           o_table_overflow,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mbec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    `include "mesh_boundary_edge_counter_defines.svh"

    localparam int AW  = $clog2(P_TABLE_DEPTH);
    localparam int VB  = P_VERTEX_BITS;
    localparam int KW  = 2 * VB;
    localparam int EW  = 1 + KW + 2;
    localparam int CW  = $clog2(P_TABLE_DEPTH + 1);
    localparam int TW  = mbec_pkg::TOTAL_W;

    mbec_pkg::t_state r_state, n_state;

    logic [VB-1:0]  r_a, r_b, r_c;
    logic [1:0]     r_edge;
    logic [KW-1:0]  r_key;
    logic [AW-1:0]  r_slot;
    logic [AW-1:0]  r_probe;
    logic [CW-1:0]  r_distinct, r_single;
    logic           r_overflow;
    logic [15:0]    r_divisor;
    logic [7:0]     r_min;
    logic           r_out_valid;
    logic [TW-1:0]  r_out_boundary, r_out_unique;
    logic           r_out_tight, r_out_few;
    logic           r_out_ovf;

    logic [VB-1:0]  e_p, e_q, e_lo, e_hi;
    logic [31:0]    m_lo, m_hi;
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata, mem_rdata;
    logic           rd_used;
    logic [KW-1:0]  rd_key;
    logic [1:0]     rd_uses;
    logic [TW-1:0]  sat_boundary, sat_unique;
    logic [28:0]    prod;
    logic           few;
    logic           in_xfer, edge_last;

    mbec_ram #(.P_WIDTH(EW), .P_DEPTH(P_TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_slot),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == mbec_pkg::S_IDLE) &&
                     (i_mode == mbec_pkg::MODE_FACE || !r_out_valid);
    assign in_xfer = i_valid && o_ready;

    always_comb begin
        case (r_edge)
            2'd0:    begin e_p = r_a; e_q = r_b; end
            2'd1:    begin e_p = r_b; e_q = r_c; end
            default: begin e_p = r_c; e_q = r_a; end
        endcase
        e_lo = (e_p < e_q) ? e_p : e_q;
        e_hi = (e_p < e_q) ? e_q : e_p;
        m_lo = 32'(e_lo) * mbec_pkg::HASH_MUL_LO;
        m_hi = 32'(e_hi) * mbec_pkg::HASH_MUL_HI;
    end

    assign rd_used   = mem_rdata[EW-1];
    assign rd_key    = mem_rdata[2 +: KW];
    assign rd_uses   = mem_rdata[1:0];
    assign edge_last = (r_edge == 2'd2);

    always_comb begin
        mem_re    = (r_state == mbec_pkg::S_READ);
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = '0;
        if (r_state == mbec_pkg::S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_probe;
        end else if (r_state == mbec_pkg::S_CHECK) begin
            if (!rd_used) begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, r_key, 2'd1};
            end else if (rd_key == r_key) begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, r_key,
                             (rd_uses == mbec_pkg::USE_MAX) ? rd_uses : rd_uses + 2'd1};
            end
        end
    end

    always_comb begin
        sat_boundary = (32'(r_single) > 32'(mbec_pkg::TOTAL_MAX))
                       ? TW'(mbec_pkg::TOTAL_MAX) : TW'(r_single);
        sat_unique   = (32'(r_distinct) > 32'(mbec_pkg::TOTAL_MAX))
                       ? TW'(mbec_pkg::TOTAL_MAX) : TW'(r_distinct);
        prod = 29'(sat_boundary) * 29'(r_divisor);
        few  = sat_unique < TW'(r_min);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mbec_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_mode == mbec_pkg::MODE_FINISH)
                              ? mbec_pkg::S_REPORT : mbec_pkg::S_HASH;
                end
            end
            mbec_pkg::S_HASH:   n_state = mbec_pkg::S_READ;
            mbec_pkg::S_READ:   n_state = mbec_pkg::S_CHECK;
            mbec_pkg::S_CHECK: begin
                if (!rd_used || rd_key == r_key || r_probe == '1) begin
                    n_state = edge_last ? mbec_pkg::S_IDLE : mbec_pkg::S_HASH;
                end else begin
                    n_state = mbec_pkg::S_READ;
                end
            end
            mbec_pkg::S_REPORT: n_state = mbec_pkg::S_CLEAR;
            mbec_pkg::S_CLEAR: begin
                if (r_probe == '1) begin
                    n_state = mbec_pkg::S_IDLE;
                end
            end
            default:            n_state = mbec_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbec_pkg::S_CLEAR;
            r_probe     <= '0;
            r_edge      <= '0;
            r_distinct  <= '0;
            r_single    <= '0;
            r_overflow  <= 1'b0;
            r_divisor   <= mbec_pkg::DIVISOR_RESET;
            r_min       <= mbec_pkg::MIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mbec_pkg::CFG_RATIO_DIVISOR: r_divisor <= i_cfg_data;
                    mbec_pkg::CFG_MIN_UNIQUE:    r_min     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                mbec_pkg::S_IDLE: begin
                    r_edge <= '0;
                end
                mbec_pkg::S_HASH: begin
                    r_probe <= '0;
                end
                mbec_pkg::S_CHECK: begin
                    if (!rd_used) begin
                        r_distinct <= r_distinct + CW'(1);
                        r_single   <= r_single + CW'(1);
                    end else if (rd_key == r_key) begin
                        if (rd_uses == 2'd1 && r_single != '0) begin
                            r_single <= r_single - CW'(1);
                        end
                    end else if (r_probe == '1) begin
                        r_overflow <= 1'b1;
                    end
                    if (!rd_used || rd_key == r_key || r_probe == '1) begin
                        r_edge <= r_edge + 2'd1;
                    end else begin
                        r_probe <= r_probe + AW'(1);
                    end
                end
                mbec_pkg::S_REPORT: begin
                    r_out_valid <= 1'b1;
                    r_distinct  <= '0;
                    r_single    <= '0;
                    r_overflow  <= 1'b0;
                    r_probe     <= '0;
                end
                mbec_pkg::S_CLEAR: begin
                    r_probe <= r_probe + AW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a <= i_corner_a;
            r_b <= i_corner_b;
            r_c <= i_corner_c;
        end
        if (r_state == mbec_pkg::S_HASH) begin
            r_key  <= {e_lo, e_hi};
            r_slot <= m_lo[AW-1:0] ^ m_hi[AW-1:0];
        end else if (r_state == mbec_pkg::S_CHECK && rd_used && rd_key != r_key) begin
            r_slot <= r_slot + AW'(1);
        end
        if (r_state == mbec_pkg::S_REPORT) begin
            r_out_boundary <= sat_boundary;
            r_out_unique   <= sat_unique;
            r_out_few      <= few;
            r_out_tight    <= few || sat_unique == '0 || prod < 29'(sat_unique);
            r_out_ovf      <= r_overflow;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_boundary_edges = r_out_boundary;
    assign o_unique_edges   = r_out_unique;
    assign o_watertight     = r_out_tight;
    assign o_too_few_edges  = r_out_few;
    assign o_table_overflow = r_out_ovf;

    `MBEC_ASSERT_IMP(a_single_le_distinct, i_clk, i_rst_n, 1'b1, r_single <= r_distinct)
    `MBEC_ASSERT_NXT(a_insert_counts, i_clk, i_rst_n,
        r_state == mbec_pkg::S_CHECK && !rd_used, r_distinct == $past(r_distinct) + CW'(1))
    `MBEC_ASSERT_IMP(a_few_is_tight, i_clk, i_rst_n,
        r_out_valid && r_out_few, r_out_tight)
endmodule

### rtl/mbec_ram.sv
`timescale 1ns / 1ps
module mbec_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
